// ===== rtl/csmf_pkg.sv =====
package csmf_pkg;

   localparam int VOL_DIM_DEF    = 64;
   localparam int MAX_RADIUS_DEF = 15;

   localparam int SIZE_W     = 7;
   localparam int RADIUS_W   = 4;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 7;
   localparam int COORD_W    = 16;
   localparam int VOXEL_W    = 6;
   localparam int VALUE_W    = 16;

   localparam logic [VALUE_W-1:0] WEIGHT_ONE = 16'd32768;

   localparam logic [SIZE_W-1:0]   SIZE_RESET   = 7'd64;
   localparam logic [RADIUS_W-1:0] RADIUS_RESET = 4'd10;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SIZE_X      = 2'd0,
      CSR_SIZE_Y      = 2'd1,
      CSR_SIZE_Z      = 2'd2,
      CSR_BLUR_RADIUS = 2'd3
   } csr_index_type;

   typedef enum logic {
      REQ_SPLAT = 1'b0,
      REQ_READ  = 1'b1
   } req_kind_type;

endpackage

// ===== rtl/cone_splat_max_field.sv =====
// Cone splatting into a VOL_DIM^3 voxel store of Q1.15 values. After reset the block
// sweeps the store to zero, one entry per cycle, and holds req_stall high meanwhile. A
// read item passes through rdv_ff and then rsp_valid_ff before rsp_valid rises; it is
// accepted only while no result is waiting. A splat item walks its clipped box one
// voxel per cycle through the distance, square-root and divide pipeline and the
// read-modify-write port of the store, so it occupies the block until its last voxel
// has left the pipeline and the store update.
module cone_splat_max_field #(
   parameter int VOL_DIM    = csmf_pkg::VOL_DIM_DEF,
   parameter int MAX_RADIUS = csmf_pkg::MAX_RADIUS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_type,
   input  logic signed [csmf_pkg::COORD_W-1:0]  req_point_x,
   input  logic signed [csmf_pkg::COORD_W-1:0]  req_point_y,
   input  logic signed [csmf_pkg::COORD_W-1:0]  req_point_z,
   input  logic [csmf_pkg::VOXEL_W-1:0]         req_voxel_x,
   input  logic [csmf_pkg::VOXEL_W-1:0]         req_voxel_y,
   input  logic [csmf_pkg::VOXEL_W-1:0]         req_voxel_z,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [csmf_pkg::VALUE_W-1:0]         rsp_voxel_value,
   input  logic                                 csr_wr_en,
   input  logic [csmf_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [csmf_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import csmf_pkg::*;

   localparam int AW    = $clog2(VOL_DIM);
   localparam int EW    = $clog2(VOL_DIM + 1);
   localparam int RW    = $clog2(MAX_RADIUS + 1);
   localparam int GW    = ((EW > 8) ? EW : 8) + 2;
   localparam int DW    = RW + 9;
   localparam int SQW   = 2 * (DW - 1);
   localparam int D2W   = SQW + 2;
   localparam int SW    = D2W + 14;
   localparam int QW    = SW / 2;
   localparam int NW    = QW + 2;
   localparam int T     = 5 + QW + NW;
   localparam int MW    = 3 * AW;
   localparam int DEPTH = 1 << MW;

   typedef struct packed {
      logic [AW-1:0] lo;
      logic [AW-1:0] hi;
      logic          empty;
   } axis_type;

   function automatic logic [RW-1:0] eff_radius(input logic [RADIUS_W-1:0] r);
      logic [RADIUS_W+1:0] rr;
      rr = {2'b00, r};
      if (rr == '0) begin
         rr = (RADIUS_W+2)'(1);
      end else if (rr > (RADIUS_W+2)'(MAX_RADIUS)) begin
         rr = (RADIUS_W+2)'(MAX_RADIUS);
      end
      return RW'(rr);
   endfunction

   function automatic logic [EW-1:0] eff_extent(input logic [SIZE_W-1:0] s);
      if (10'(s) > 10'(VOL_DIM)) begin
         return EW'(VOL_DIM);
      end
      return EW'(s);
   endfunction

   function automatic axis_type axis_span(input logic signed [COORD_W-1:0] p,
                                          input logic [RW-1:0] r,
                                          input logic [EW-1:0] ext);
      logic signed [GW-1:0] f;
      logic signed [GW-1:0] rs;
      logic signed [GW-1:0] lo;
      logic signed [GW-1:0] hi;
      logic signed [GW-1:0] top;
      axis_type a;
      f   = GW'(p >>> 8);
      rs  = GW'($signed({1'b0, r}));
      top = GW'($signed({1'b0, ext})) - GW'(1);
      lo  = f - rs;
      hi  = f + rs;
      if (lo < 0) begin
         lo = '0;
      end
      if (hi > top) begin
         hi = top;
      end
      a.empty = (lo > hi);
      a.lo    = AW'(lo);
      a.hi    = AW'(hi);
      return a;
   endfunction

   // Offsets are taken modulo 2^DW; voxels of the box are always close enough to fit.
   function automatic logic signed [DW-1:0] offset(input logic [AW-1:0] v,
                                                   input logic signed [COORD_W-1:0] p);
      return $signed(DW'({v, 8'b0}) - DW'(p));
   endfunction

   // Configuration
   logic [SIZE_W-1:0]   size_x_ff, size_y_ff, size_z_ff;
   logic [RADIUS_W-1:0] radius_ff;
   logic [EW-1:0]       ext_x, ext_y, ext_z;
   logic [RW-1:0]       r_eff;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_x_ff <= SIZE_RESET;
         size_y_ff <= SIZE_RESET;
         size_z_ff <= SIZE_RESET;
         radius_ff <= RADIUS_RESET;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_SIZE_X:      size_x_ff <= csr_wdata;
            CSR_SIZE_Y:      size_y_ff <= csr_wdata;
            CSR_SIZE_Z:      size_z_ff <= csr_wdata;
            CSR_BLUR_RADIUS: radius_ff <= csr_wdata[RADIUS_W-1:0];
            default:         ;
         endcase
      end
   end

   assign ext_x = eff_extent(size_x_ff);
   assign ext_y = eff_extent(size_y_ff);
   assign ext_z = eff_extent(size_z_ff);
   assign r_eff = eff_radius(radius_ff);

   // Handshake and control
   logic clearing_ff;
   logic [MW:0] clr_ff;
   logic gen_active_ff;
   logic tag_v_ff [T];
   logic [MW-1:0] tag_a_ff [T];
   logic upd_v_ff;
   logic [MW-1:0] upd_a_ff;
   logic [VALUE_W-1:0] upd_w_ff;
   logic rdv_ff, rd_in_ff;
   logic rsp_valid_ff;
   logic [VALUE_W-1:0] rsp_value_ff;
   logic pipe_busy, busy, accept, acc_read, acc_splat;

   always_comb begin
      pipe_busy = 1'b0;
      for (int k = 0; k < T; k++) begin
         pipe_busy = pipe_busy | tag_v_ff[k];
      end
   end

   assign busy      = clearing_ff | gen_active_ff | pipe_busy | upd_v_ff | rdv_ff;
   assign req_stall = busy | rsp_valid_ff;
   assign accept    = req_valid & ~req_stall;
   assign acc_read  = accept & (req_kind_type'(req_type) == REQ_READ);
   assign acc_splat = accept & (req_kind_type'(req_type) == REQ_SPLAT);

   // Box walk
   axis_type ax, ay, az;
   logic [AW-1:0] gx_ff, gy_ff, gz_ff;
   logic [AW-1:0] hx_ff, ly_ff, hy_ff, lz_ff, hz_ff;
   logic signed [COORD_W-1:0] px_ff, py_ff, pz_ff;

   assign ax = axis_span(req_point_x, r_eff, ext_x);
   assign ay = axis_span(req_point_y, r_eff, ext_y);
   assign az = axis_span(req_point_z, r_eff, ext_z);

   always_ff @(posedge clock) begin
      if (reset) begin
         gen_active_ff <= 1'b0;
      end else if (acc_splat) begin
         gen_active_ff <= ~(ax.empty | ay.empty | az.empty);
      end else if (gen_active_ff && gz_ff == hz_ff && gy_ff == hy_ff && gx_ff == hx_ff) begin
         gen_active_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (acc_splat) begin
         gx_ff <= ax.lo;
         gy_ff <= ay.lo;
         gz_ff <= az.lo;
         hx_ff <= ax.hi;
         ly_ff <= ay.lo;
         hy_ff <= ay.hi;
         lz_ff <= az.lo;
         hz_ff <= az.hi;
         px_ff <= req_point_x;
         py_ff <= req_point_y;
         pz_ff <= req_point_z;
      end else if (gen_active_ff) begin
         if (gz_ff == hz_ff) begin
            gz_ff <= lz_ff;
            if (gy_ff == hy_ff) begin
               gy_ff <= ly_ff;
               gx_ff <= gx_ff + AW'(1);
            end else begin
               gy_ff <= gy_ff + AW'(1);
            end
         end else begin
            gz_ff <= gz_ff + AW'(1);
         end
      end
   end

   // Tag line: valid and store address travel with the weight pipeline.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < T; k++) begin
            tag_v_ff[k] <= 1'b0;
         end
      end else begin
         tag_v_ff[0] <= gen_active_ff;
         for (int k = 1; k < T; k++) begin
            tag_v_ff[k] <= tag_v_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      tag_a_ff[0] <= {gx_ff, gy_ff, gz_ff};
      for (int k = 1; k < T; k++) begin
         tag_a_ff[k] <= tag_a_ff[k-1];
      end
   end

   // Squared distance in 1/65536 voxel^2, scaled by 2^14.
   logic signed [DW-1:0]   dx_ff, dy_ff, dz_ff;
   logic signed [2*DW-1:0] mx, my, mz;
   logic [SQW-1:0]         sqx_ff, sqy_ff, sqz_ff;
   logic [SW-1:0]          s_ff;

   assign mx = dx_ff * dx_ff;
   assign my = dy_ff * dy_ff;
   assign mz = dz_ff * dz_ff;

   always_ff @(posedge clock) begin
      dx_ff  <= offset(gx_ff, px_ff);
      dy_ff  <= offset(gy_ff, py_ff);
      dz_ff  <= offset(gz_ff, pz_ff);
      sqx_ff <= SQW'(mx);
      sqy_ff <= SQW'(my);
      sqz_ff <= SQW'(mz);
      s_ff   <= {D2W'(sqx_ff) + D2W'(sqy_ff) + D2W'(sqz_ff), 14'b0};
   end

   // Square root, one result bit per stage.
   logic [SW-1:0]   sq_s_ff    [QW];
   logic [QW+1:0]   sq_rem_ff  [QW];
   logic [QW-1:0]   sq_root_ff [QW];
   logic [SW-1:0]   sq_s_in    [QW];
   logic [QW+1:0]   sq_rem_in  [QW];
   logic [QW-1:0]   sq_root_in [QW];

   always_comb begin
      logic [SW-1:0] is;
      logic [QW+1:0] ir;
      logic [QW-1:0] iq;
      logic [QW+1:0] r2;
      logic [QW+1:0] trial;
      for (int j = 0; j < QW; j++) begin
         if (j == 0) begin
            is = s_ff;
            ir = '0;
            iq = '0;
         end else begin
            is = sq_s_ff[j-1];
            ir = sq_rem_ff[j-1];
            iq = sq_root_ff[j-1];
         end
         r2    = {ir[QW-1:0], is[SW-1:SW-2]};
         trial = {iq, 2'b01};
         if (r2 >= trial) begin
            sq_rem_in[j]  = r2 - trial;
            sq_root_in[j] = {iq[QW-2:0], 1'b1};
         end else begin
            sq_rem_in[j]  = r2;
            sq_root_in[j] = {iq[QW-2:0], 1'b0};
         end
         sq_s_in[j] = is << 2;
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < QW; j++) begin
         sq_s_ff[j]    <= sq_s_in[j];
         sq_rem_ff[j]  <= sq_rem_in[j];
         sq_root_ff[j] <= sq_root_in[j];
      end
   end

   // Ceiling of the root, then ceiling of root / r as floor((m + r - 1) / r).
   logic [NW-1:0] n_ff;

   always_ff @(posedge clock) begin
      n_ff <= NW'(sq_root_ff[QW-1]) + NW'(sq_rem_ff[QW-1] != '0) + NW'(r_eff) - NW'(1);
   end

   logic [NW-1:0] dv_n_ff   [NW];
   logic [RW-1:0] dv_rem_ff [NW];
   logic [NW-1:0] dv_q_ff   [NW];
   logic [NW-1:0] dv_n_in   [NW];
   logic [RW-1:0] dv_rem_in [NW];
   logic [NW-1:0] dv_q_in   [NW];

   always_comb begin
      logic [NW-1:0] inn;
      logic [RW-1:0] inr;
      logic [NW-1:0] inq;
      logic [RW:0]   t;
      for (int j = 0; j < NW; j++) begin
         if (j == 0) begin
            inn = n_ff;
            inr = '0;
            inq = '0;
         end else begin
            inn = dv_n_ff[j-1];
            inr = dv_rem_ff[j-1];
            inq = dv_q_ff[j-1];
         end
         t = {inr, inn[NW-1]};
         if (t >= {1'b0, r_eff}) begin
            dv_rem_in[j] = RW'(t - {1'b0, r_eff});
            dv_q_in[j]   = {inq[NW-2:0], 1'b1};
         end else begin
            dv_rem_in[j] = RW'(t);
            dv_q_in[j]   = {inq[NW-2:0], 1'b0};
         end
         dv_n_in[j] = inn << 1;
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < NW; j++) begin
         dv_n_ff[j]   <= dv_n_in[j];
         dv_rem_ff[j] <= dv_rem_in[j];
         dv_q_ff[j]   <= dv_q_in[j];
      end
   end

   logic [VALUE_W-1:0] w_ff;

   always_ff @(posedge clock) begin
      if (dv_q_ff[NW-1] >= NW'(WEIGHT_ONE)) begin
         w_ff <= '0;
      end else begin
         w_ff <= WEIGHT_ONE - VALUE_W'(dv_q_ff[NW-1]);
      end
   end

   // Voxel store: one read and one write port, read data registered.
   logic [VALUE_W-1:0] mem [DEPTH];
   logic [VALUE_W-1:0] rd_data_ff;
   logic [MW-1:0]      mem_ra, mem_wa;
   logic [VALUE_W-1:0] mem_wd;
   logic               mem_we, rd_in_range;

   assign rd_in_range = (10'(req_voxel_x) < 10'(ext_x)) && (10'(req_voxel_y) < 10'(ext_y))
                        && (10'(req_voxel_z) < 10'(ext_z));

   always_comb begin
      if (acc_read) begin
         mem_ra = {AW'(req_voxel_x), AW'(req_voxel_y), AW'(req_voxel_z)};
      end else begin
         mem_ra = tag_a_ff[T-1];
      end
      if (clearing_ff) begin
         mem_we = 1'b1;
         mem_wa = clr_ff[MW-1:0];
         mem_wd = '0;
      end else begin
         mem_we = upd_v_ff && (upd_w_ff > rd_data_ff);
         mem_wa = upd_a_ff;
         mem_wd = upd_w_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rd_data_ff <= mem[mem_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_ff      <= '0;
      end else if (clearing_ff) begin
         clr_ff <= clr_ff + (MW+1)'(1);
         if (clr_ff == (MW+1)'(DEPTH - 1)) begin
            clearing_ff <= 1'b0;
         end
      end
   end

   // Each voxel appears once per splat, so the read of one voxel never meets the
   // write of the same voxel; the next item waits until the pipeline has drained.
   always_ff @(posedge clock) begin
      if (reset) begin
         upd_v_ff <= 1'b0;
         rdv_ff   <= 1'b0;
      end else begin
         upd_v_ff <= tag_v_ff[T-1];
         rdv_ff   <= acc_read;
      end
   end

   always_ff @(posedge clock) begin
      upd_a_ff <= tag_a_ff[T-1];
      upd_w_ff <= w_ff;
      if (acc_read) begin
         rd_in_ff <= rd_in_range;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rdv_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rdv_ff) begin
         rsp_value_ff <= rd_in_ff ? rd_data_ff : '0;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_voxel_value = rsp_value_ff;

endmodule

// ===== rtl/csmf_checker.sv =====
module csmf_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_stall,
   input logic                                req_type,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic [csmf_pkg::VALUE_W-1:0]        rsp_voxel_value
);
   import csmf_pkg::*;

   logic acc_read, acc_splat;

   assign acc_read  = req_valid && !req_stall && (req_type == REQ_READ);
   assign acc_splat = req_valid && !req_stall && (req_type == REQ_SPLAT);

   // A read item gives its result through rdv_ff and then rsp_valid_ff after acceptance.
   a_read_latency: assert property (@(posedge clock) disable iff (reset)
      acc_read |=> !rsp_valid ##1 rsp_valid)
      else $error("read item did not produce a result on time");

   // A splat item never produces a result.
   a_splat_silent: assert property (@(posedge clock) disable iff (reset)
      acc_splat && !rsp_valid |=> !rsp_valid ##1 !rsp_valid)
      else $error("splat item produced a result");

   // Stored weights never exceed 1.0.
   a_value_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_voxel_value <= WEIGHT_ONE)
      else $error("voxel value above 1.0");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_voxel_value))
      else $error("stalled result changed");

endmodule

bind cone_splat_max_field csmf_checker u_csmf_checker (.*);

// ===== verif/tb_cone_splat_max_field.sv =====
`timescale 1ns / 100ps

module tb_cone_splat_max_field;
   import csmf_pkg::*;

   localparam int DIM        = VOL_DIM_DEF;
   localparam int CYCLE_CAP  = 4000000;
   localparam int LONG_HOLD  = 300;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_type = REQ_SPLAT;
   logic signed [COORD_W-1:0] req_point_x = '0, req_point_y = '0, req_point_z = '0;
   logic [VOXEL_W-1:0] req_voxel_x = '0, req_voxel_y = '0, req_voxel_z = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [VALUE_W-1:0] rsp_voxel_value;
   logic csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_SIZE_X;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // Mirror of the voxel store and of the registers.
   bit [VALUE_W-1:0] field_mirror [0:DIM*DIM*DIM-1];
   bit [SIZE_W-1:0] mirror_size [3];
   bit [RADIUS_W-1:0] mirror_radius;

   bit [VALUE_W-1:0] expected_values [$];
   int errors = 0;
   int cycle_count = 0;
   bit gaps_on = 1'b1;
   bit hold_request = 1'b0;
   int last_fx, last_fy, last_fz;

   cone_splat_max_field u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_type(req_type),
      .req_point_x(req_point_x), .req_point_y(req_point_y), .req_point_z(req_point_z),
      .req_voxel_x(req_voxel_x), .req_voxel_y(req_voxel_y), .req_voxel_z(req_voxel_z),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_voxel_value(rsp_voxel_value),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_CAP) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   task automatic report(input string msg);
      $display("ERROR at cycle %0d: %s", cycle_count, msg);
      errors++;
   endtask

   function automatic int clip_extent(input bit [SIZE_W-1:0] s);
      return (s > DIM) ? DIM : int'(s);
   endfunction

   function automatic int eff_radius();
      if (mirror_radius == 0) return 1;
      if (mirror_radius > MAX_RADIUS_DEF) return MAX_RADIUS_DEF;
      return int'(mirror_radius);
   endfunction

   // Smallest m with m*m >= s.
   function automatic longint unsigned sqrt_up(input longint unsigned s);
      longint unsigned root, bitv, rem;
      root = 0;
      bitv = 64'd1 << 62;
      rem = s;
      while (bitv > rem) bitv >>= 2;
      while (bitv != 0) begin
         if (rem >= root + bitv) begin
            rem -= root + bitv;
            root = (root >> 1) + bitv;
         end else begin
            root >>= 1;
         end
         bitv >>= 2;
      end
      if (root * root < s) root++;
      return root;
   endfunction

   function automatic bit [VALUE_W-1:0] cone_weight(input longint unsigned d2, input int r);
      longint unsigned m, k;
      m = sqrt_up(d2 * 16384);
      k = (m + r - 1) / r;
      if (k >= 32768) return '0;
      return VALUE_W'(32768 - k);
   endfunction

   function automatic void splat_into_mirror(input logic signed [COORD_W-1:0] p [3]);
      int lo [3], hi [3];
      int r, f, x, y, z, idx;
      longint dx, dy, dz;
      bit [VALUE_W-1:0] w;
      r = eff_radius();
      for (int a = 0; a < 3; a++) begin
         f = int'(p[a]) >>> 8;
         lo[a] = (f - r < 0) ? 0 : f - r;
         hi[a] = (f + r > clip_extent(mirror_size[a]) - 1) ?
                 clip_extent(mirror_size[a]) - 1 : f + r;
      end
      for (x = lo[0]; x <= hi[0]; x++) begin
         dx = longint'(x) * 256 - longint'(p[0]);
         for (y = lo[1]; y <= hi[1]; y++) begin
            dy = longint'(y) * 256 - longint'(p[1]);
            for (z = lo[2]; z <= hi[2]; z++) begin
               dz = longint'(z) * 256 - longint'(p[2]);
               w = cone_weight(dx * dx + dy * dy + dz * dz, r);
               idx = (x * DIM + y) * DIM + z;
               if (w > field_mirror[idx]) field_mirror[idx] = w;
            end
         end
      end
   endfunction

   task automatic send_item(input req_kind_type kind,
                            input logic signed [COORD_W-1:0] px, py, pz,
                            input logic [VOXEL_W-1:0] vx, vy, vz);
      int gap;
      logic signed [COORD_W-1:0] pt [3];
      gap = gaps_on ? $urandom_range(0, 11) : 0;
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_type <= kind;
      req_point_x <= px;
      req_point_y <= py;
      req_point_z <= pz;
      req_voxel_x <= vx;
      req_voxel_y <= vy;
      req_voxel_z <= vz;
      do @(posedge clock); while (req_stall);
      if (kind == REQ_READ) begin
         if (vx < clip_extent(mirror_size[0]) && vy < clip_extent(mirror_size[1]) &&
             vz < clip_extent(mirror_size[2]))
            expected_values.push_back(field_mirror[(int'(vx) * DIM + vy) * DIM + vz]);
         else
            expected_values.push_back('0);
      end else begin
         pt[0] = px;
         pt[1] = py;
         pt[2] = pz;
         splat_into_mirror(pt);
         last_fx = int'(px) >>> 8;
         last_fy = int'(py) >>> 8;
         last_fz = int'(pz) >>> 8;
      end
   endtask

   task automatic splat(input int px, py, pz);
      send_item(REQ_SPLAT, COORD_W'(px), COORD_W'(py), COORD_W'(pz),
                VOXEL_W'($urandom), VOXEL_W'($urandom), VOXEL_W'($urandom));
   endtask

   task automatic read_voxel(input int vx, vy, vz);
      send_item(REQ_READ, COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
                VOXEL_W'(vx), VOXEL_W'(vy), VOXEL_W'(vz));
   endtask

   // A splat gives no result, so after the last read the block may still be
   // walking a box; wait out the largest box at the current radius.
   task automatic wait_idle();
      int r;
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_values.size() != 0) @(posedge clock);
      r = eff_radius();
      repeat ((2 * r + 1) ** 3 + 100) @(posedge clock);
   endtask

   task automatic apply_config(input int sx, sy, sz, r);
      int vals [4];
      vals = '{sx, sy, sz, r};
      wait_idle();
      for (int i = 0; i < 4; i++) begin
         @(negedge clock);
         csr_wr_en <= 1'b1;
         csr_index <= csr_index_type'(i);
         csr_wdata <= CSR_DATA_W'(vals[i]);
         if (i < 3) mirror_size[i] = SIZE_W'(vals[i]);
         else mirror_radius = RADIUS_W'(vals[i]);
      end
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Result checker.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_values.size() == 0) begin
            report($sformatf("unexpected voxel_value %0d", rsp_voxel_value));
         end else if (rsp_voxel_value !== expected_values[0]) begin
            report($sformatf("voxel_value %0d, expected %0d",
                             rsp_voxel_value, expected_values[0]));
            void'(expected_values.pop_front());
         end else begin
            void'(expected_values.pop_front());
         end
      end
   end

   // Result receiver: a random hold-off before each item, or a long one on request.
   initial begin
      int hold;
      forever begin
         hold = $urandom_range(0, 11);
         if (!gaps_on) hold = 0;
         if (hold_request) begin
            hold = LONG_HOLD;
            hold_request = 1'b0;
         end
         repeat (hold) begin
            @(negedge clock);
            rsp_stall <= 1'b1;
         end
         @(negedge clock);
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
      end
   end

   task automatic test_directed();
      read_voxel(0, 0, 0);
      splat(32 * 256, 32 * 256, 32 * 256);
      read_voxel(32, 32, 32);
      read_voxel(35, 32, 32);
      read_voxel(42, 32, 32);
      read_voxel(36, 29, 34);
      read_voxel(63, 63, 63);
      // Points far outside the volume leave an empty box.
      splat(-32768, -32768, -32768);
      splat(32767, 32767, 32767);
      splat(0, 0, 0);
      read_voxel(0, 0, 0);
      read_voxel(5, 3, 1);
      splat(10 * 256 + 128, 20 * 256 + 64, 16383);
      read_voxel(10, 20, 63);
      read_voxel(11, 21, 60);
      read_voxel(63, 63, 63);
      read_voxel(0, 63, 0);
   endtask

   task automatic test_config_extremes();
      apply_config(1, 1, 1, 1);
      splat(128, 128, 128);
      read_voxel(0, 0, 0);
      read_voxel(1, 0, 0);
      read_voxel(0, 0, 63);
      // An extent of zero is an empty volume.
      apply_config(0, 0, 0, 0);
      splat(0, 0, 0);
      read_voxel(0, 0, 0);
      // Oversized extents clip to the store; radius at its bound.
      apply_config(127, 127, 127, 15);
      splat(40 * 256 + 77, 50 * 256 + 200, 45 * 256 + 3);
      read_voxel(40, 50, 45);
      read_voxel(55, 63, 58);
      read_voxel(27, 40, 31);
   endtask

   task automatic test_backpressure();
      apply_config(64, 64, 64, 2);
      splat(20 * 256 + 30, 20 * 256 + 90, 20 * 256 + 250);
      hold_request = 1'b1;
      gaps_on = 1'b0;
      for (int i = 0; i < 12; i++)
         read_voxel(19 + $urandom_range(0, 3), 19 + $urandom_range(0, 3),
                    19 + $urandom_range(0, 3));
      gaps_on = 1'b1;
   endtask

   task automatic test_random();
      int sz [3];
      int r, sel;
      for (int phase = 0; phase < 4; phase++) begin
         for (int a = 0; a < 3; a++) begin
            sel = $urandom_range(0, 9);
            sz[a] = (sel == 0) ? $urandom_range(65, 127) :
                    (sel == 1) ? 0 : $urandom_range(1, 64);
         end
         r = (phase == 3) ? $urandom_range(5, 8) : $urandom_range(0, 4);
         apply_config(sz[0], sz[1], sz[2], r);
         gaps_on = (phase != 1);
         for (int i = 0; i < 15; i++) begin
            if ($urandom_range(0, 9) < 5) begin
               if ($urandom_range(0, 9) == 0)
                  splat($urandom, $urandom, $urandom);
               else
                  splat($urandom_range(0, 64 * 256 - 1), $urandom_range(0, 64 * 256 - 1),
                        $urandom_range(0, 64 * 256 - 1));
            end else if ($urandom_range(0, 9) < 7) begin
               read_voxel((last_fx + $urandom_range(0, 2 * r) - r) & 63,
                          (last_fy + $urandom_range(0, 2 * r) - r) & 63,
                          (last_fz + $urandom_range(0, 2 * r) - r) & 63);
            end else begin
               read_voxel($urandom, $urandom, $urandom);
            end
         end
         gaps_on = 1'b1;
      end
   endtask

   initial begin
      mirror_size = '{SIZE_RESET, SIZE_RESET, SIZE_RESET};
      mirror_radius = RADIUS_RESET;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_config_extremes();
      test_backpressure();
      test_random();
      wait_idle();
      if (errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
